@@ src/shs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_pkg: shared types and constants of the stall homing sequencer
// Item and result layouts, configuration record, action codes, fixed powers.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int POSITION_WIDTH = 24;

  typedef logic signed [POSITION_WIDTH-1:0] pos_t;

  // action codes
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_MOVE  = 2'd1;
  localparam logic [1:0] ACT_POWER = 2'd2;
  localparam logic [1:0] ACT_HOLD  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_CHORD_WINDOW = 3'd0;
  localparam logic [2:0] REG_GRACE        = 3'd1;
  localparam logic [2:0] REG_TIMEOUT      = 3'd2;
  localparam logic [2:0] REG_CUR_LIMIT    = 3'd3;
  localparam logic [2:0] REG_STALL_EPS    = 3'd4;
  localparam logic [2:0] REG_STALL_LIMIT  = 3'd5;
  localparam logic [2:0] REG_MATCH_ANGLE  = 3'd6;
  localparam logic [2:0] REG_PAR_ANGLE    = 3'd7;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = POSITION_WIDTH;

  // 50 deg step in 1/256 deg, open-loop powers
  localparam int                STEP_COUNTS  = 12800;
  localparam logic signed [7:0] PWR_HOMING   = -8'sd40;
  localparam logic signed [7:0] PWR_JOG_UP   = 8'sd76;
  localparam logic signed [7:0] PWR_JOG_DOWN = -8'sd76;

  typedef struct packed {
    logic [15:0] chord_window;
    logic [15:0] grace;
    logic [15:0] timeout;
    logic [11:0] cur_limit;
    logic [15:0] stall_eps;
    logic [7:0]  stall_limit;
    pos_t        match_angle;
    pos_t        par_angle;
  } cfg_t;

  // first field in the highest bits
  typedef struct packed {
    logic [11:0] motor_current;
    pos_t        joint_position;
    logic        jog_down;
    logic        jog_up;
    logic        button_b;
    logic        button_a;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic              homing_active;
    logic              zeroed;
    logic              tare;
    logic signed [7:0] drive_power;
    pos_t              target_angle;
    logic [1:0]        action;
  } res_t;

  localparam int IN_DATA_W  = ((($bits(item_t)) + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((($bits(res_t)) + 7) / 8) * 8;

endpackage

@@ src/shs_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_cfg: configuration register file
// Write-only registers, decoded by index, with their reset values.
// ----------------------------------------------------------------------------
module shs_cfg import shs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_CHORD_WINDOW: cfg_nxt.chord_window = cfg_wdata[15:0];
        REG_GRACE:        cfg_nxt.grace        = cfg_wdata[15:0];
        REG_TIMEOUT:      cfg_nxt.timeout      = cfg_wdata[15:0];
        REG_CUR_LIMIT:    cfg_nxt.cur_limit    = cfg_wdata[11:0];
        REG_STALL_EPS:    cfg_nxt.stall_eps    = cfg_wdata[15:0];
        REG_STALL_LIMIT:  cfg_nxt.stall_limit  = cfg_wdata[7:0];
        REG_MATCH_ANGLE:  cfg_nxt.match_angle  = pos_t'(cfg_wdata[POSITION_WIDTH-1:0]);
        REG_PAR_ANGLE:    cfg_nxt.par_angle    = pos_t'(cfg_wdata[POSITION_WIDTH-1:0]);
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chord_window <= 16'd100;
      cfg_r.grace        <= 16'd250;
      cfg_r.timeout      <= 16'd3000;
      cfg_r.cur_limit    <= 12'd1200;
      cfg_r.stall_eps    <= 16'd77;
      cfg_r.stall_limit  <= 8'd10;
      cfg_r.match_angle  <= pos_t'(25600);
      cfg_r.par_angle    <= pos_t'(23040);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/shs_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_core: sequencer state and per-tick step logic
// Chord detection, homing run, manual jog; updates state on each step.
// ----------------------------------------------------------------------------
module shs_core import shs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  step_en,
  input  item_t item,
  output res_t  res
);

  logic        prev_a_r, prev_b_r, pending_a_r, pending_b_r;
  logic        homing_r, zero_known_r, jogging_r, jog_tared_r;
  logic [31:0] press_time_a_r, press_time_b_r, run_start_r;
  logic [7:0]  stall_count_r;
  pos_t        last_pos_r;

  logic        pending_a_nxt, pending_b_nxt;
  logic        homing_nxt, zero_known_nxt, jogging_nxt, jog_tared_nxt;
  logic [31:0] press_time_a_nxt, press_time_b_nxt, run_start_nxt;
  logic [7:0]  stall_count_nxt;
  pos_t        last_pos_nxt;

  // one stall evaluation: over-current or movement below epsilon
  function automatic logic [7:0] stall_upd(input pos_t pos, input pos_t last,
                                           input logic [11:0] cur, input cfg_t c,
                                           input logic [7:0] cnt);
    logic signed [POSITION_WIDTH:0] diff;
    logic [POSITION_WIDTH:0]        mag;
    logic                           stalled;
    diff = {pos[POSITION_WIDTH-1], pos} - {last[POSITION_WIDTH-1], last};
    mag  = diff[POSITION_WIDTH] ? (POSITION_WIDTH+1)'(-diff) : diff;
    stalled = (cur >= c.cur_limit) ||
              (mag < {{(POSITION_WIDTH+1-16){1'b0}}, c.stall_eps});
    if (stalled) begin
      stall_upd = (cnt == 8'hFF) ? cnt : cnt + 8'd1;
    end else begin
      stall_upd = 8'd0;
    end
  endfunction

  always_comb begin : step
    logic                           rise_a, rise_b;
    logic [31:0]                    el;
    logic                           contact;
    logic signed [POSITION_WIDTH:0] up_sum;
    pos_t                           step_tgt;

    rise_a = item.button_a & ~prev_a_r;
    rise_b = item.button_b & ~prev_b_r;
    el      = '0;
    contact = 1'b0;

    pending_a_nxt    = pending_a_r | rise_a;
    pending_b_nxt    = pending_b_r | rise_b;
    press_time_a_nxt = rise_a ? item.now_ms : press_time_a_r;
    press_time_b_nxt = rise_b ? item.now_ms : press_time_b_r;
    homing_nxt       = homing_r;
    zero_known_nxt   = zero_known_r;
    jogging_nxt      = jogging_r;
    jog_tared_nxt    = jog_tared_r;
    run_start_nxt    = run_start_r;
    stall_count_nxt  = stall_count_r;
    last_pos_nxt     = last_pos_r;

    res = '0;

    // single press steps up 50 deg, saturating at the top of the range
    up_sum = {item.joint_position[POSITION_WIDTH-1], item.joint_position}
           + (POSITION_WIDTH+1)'(STEP_COUNTS);
    if (up_sum[POSITION_WIDTH] != up_sum[POSITION_WIDTH-1]) begin
      step_tgt = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
    end else begin
      step_tgt = up_sum[POSITION_WIDTH-1:0];
    end

    // chord / single press resolution
    if (pending_a_nxt && pending_b_nxt) begin
      homing_nxt       = 1'b0;
      res.action       = ACT_MOVE;
      res.target_angle = cfg.match_angle;
      pending_a_nxt    = 1'b0;
      pending_b_nxt    = 1'b0;
    end else if (pending_a_nxt &&
                 (item.now_ms - press_time_a_nxt) >= {16'd0, cfg.chord_window}) begin
      homing_nxt       = 1'b0;
      res.action       = ACT_MOVE;
      res.target_angle = zero_known_r ? cfg.par_angle : step_tgt;
      pending_a_nxt    = 1'b0;
    end else if (pending_b_nxt &&
                 (item.now_ms - press_time_b_nxt) >= {16'd0, cfg.chord_window}) begin
      homing_nxt      = 1'b1;
      run_start_nxt   = item.now_ms;
      stall_count_nxt = 8'd0;
      last_pos_nxt    = item.joint_position;
      pending_b_nxt   = 1'b0;
    end

    // homing run
    if (homing_nxt) begin
      el              = item.now_ms - run_start_nxt;
      contact         = 1'b0;
      res.action      = ACT_POWER;
      res.drive_power = PWR_HOMING;
      if (el >= {16'd0, cfg.grace}) begin
        stall_count_nxt = stall_upd(item.joint_position, last_pos_nxt,
                                    item.motor_current, cfg, stall_count_nxt);
        contact = (stall_count_nxt >= cfg.stall_limit) || (el >= {16'd0, cfg.timeout});
      end
      last_pos_nxt = item.joint_position;
      if (contact) begin
        res.action      = ACT_HOLD;
        res.drive_power = 8'sd0;
        res.tare        = 1'b1;
        zero_known_nxt  = 1'b1;
        homing_nxt      = 1'b0;
        stall_count_nxt = 8'd0;
      end
    end

    // manual jog overrides the tick
    if (item.jog_up || item.jog_down) begin
      if (!jogging_r) begin
        homing_nxt      = 1'b0;
        stall_count_nxt = 8'd0;
        jog_tared_nxt   = 1'b0;
        last_pos_nxt    = item.joint_position;
        run_start_nxt   = item.now_ms;
      end
      res.action       = ACT_POWER;
      res.target_angle = '0;
      res.drive_power  = item.jog_up ? PWR_JOG_UP : PWR_JOG_DOWN;
      jogging_nxt      = 1'b1;
      if (item.jog_down && !jog_tared_nxt) begin
        if ((item.now_ms - run_start_nxt) >= {16'd0, cfg.grace}) begin
          stall_count_nxt = stall_upd(item.joint_position, last_pos_nxt,
                                      item.motor_current, cfg, stall_count_nxt);
          if (stall_count_nxt >= cfg.stall_limit) begin
            res.drive_power = 8'sd0;
            res.tare        = 1'b1;
            zero_known_nxt  = 1'b1;
            jog_tared_nxt   = 1'b1;
            stall_count_nxt = 8'd0;
          end
        end
        last_pos_nxt = item.joint_position;
      end
    end else if (jogging_r) begin
      res.action       = ACT_HOLD;
      res.target_angle = '0;
      res.drive_power  = 8'sd0;
      jogging_nxt      = 1'b0;
    end

    if (res.action != ACT_MOVE) begin
      res.target_angle = '0;
    end
    if (res.action != ACT_POWER) begin
      res.drive_power = 8'sd0;
    end
    res.zeroed        = zero_known_nxt;
    res.homing_active = homing_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r       <= 1'b0;
      prev_b_r       <= 1'b0;
      pending_a_r    <= 1'b0;
      pending_b_r    <= 1'b0;
      press_time_a_r <= '0;
      press_time_b_r <= '0;
      homing_r       <= 1'b0;
      run_start_r    <= '0;
      stall_count_r  <= '0;
      last_pos_r     <= '0;
      zero_known_r   <= 1'b0;
      jogging_r      <= 1'b0;
      jog_tared_r    <= 1'b0;
    end else if (step_en) begin
      prev_a_r       <= item.button_a;
      prev_b_r       <= item.button_b;
      pending_a_r    <= pending_a_nxt;
      pending_b_r    <= pending_b_nxt;
      press_time_a_r <= press_time_a_nxt;
      press_time_b_r <= press_time_b_nxt;
      homing_r       <= homing_nxt;
      run_start_r    <= run_start_nxt;
      stall_count_r  <= stall_count_nxt;
      last_pos_r     <= last_pos_nxt;
      zero_known_r   <= zero_known_nxt;
      jogging_r      <= jogging_nxt;
      jog_tared_r    <= jog_tared_nxt;
    end
  end

  // a zero, once taken, is never lost
  a_zero_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    zero_known_r |=> zero_known_r)
    else $error("zero reference dropped");

  // a chord is always consumed in the tick it completes
  a_no_both_pending: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> !(pending_a_r && pending_b_r))
    else $error("both buttons left pending");

  // a step without tare never establishes the zero
  a_zero_needs_tare: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && !res.tare && !zero_known_r) |=> !zero_known_r)
    else $error("zero set without tare");

endmodule

@@ src/stall_homing_sequencer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stall_homing_sequencer_top: claw pivot sequencer with stall homing
// Input register, combinational step logic, result register; stream ports.
// ----------------------------------------------------------------------------
// One control tick per input transaction produces exactly one result
// transaction. A tick is captured in an input register, evaluated
// combinationally against the sequencer state (chord window, homing run,
// manual jog) and written to a result register when that register is free
// or being drained, and a new tick can be accepted every cycle; the
// sustained rate is one transaction per clock, limited only by the result
// consumer.
// The input stage keeps accepting while a finished result waits, as long as
// the result register is free or being drained in the same cycle.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata and
// must only change while no tick is in flight. Times are milliseconds and
// wrap modulo 2^32; positions are signed, 1/256 degree.
// ----------------------------------------------------------------------------
module stall_homing_sequencer_top import shs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // now_ms[31:0], button_a[32], button_b[33], jog_up[34], jog_down[35],
  // joint_position[59:36], motor_current[71:60]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[1:0], target_angle[25:2], drive_power[33:26], tare[34],
  // zeroed[35], homing_active[36], zero fill above
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg;
  item_t item_r;
  logic  in_valid_r;
  res_t  res;
  res_t  res_r;
  logic  out_valid_r;
  logic  advance;
  logic  out_valid_nxt;

  // step the tick in the input register when the result slot frees up
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_t'(in_tdata[$bits(item_t)-1:0]);
    end
    if (advance) begin
      res_r <= res;
    end
  end

  shs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  shs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step_en (advance),
    .item    (item_r),
    .res     (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-$bits(res_t)){1'b0}}, res_r};

  // a tare always leaves the joint zeroed
  a_tare_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!res_r.tare || res_r.zeroed))
    else $error("tare reported without zero");

  // target only carries a value on a move, power only on open-loop drive
  a_target_only_move: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.action != ACT_MOVE) |-> (res_r.target_angle == '0))
    else $error("target set outside a move");

  a_power_only_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.action != ACT_POWER) |-> (res_r.drive_power == 8'sd0))
    else $error("power set outside open-loop drive");

endmodule

@@ test/shs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_checker: result predictor and comparator for the stall homing sequencer
// Follows every tick transaction and register write, keeps its own copy of
// the sequencer state, and checks each result transaction in order.
// ----------------------------------------------------------------------------
module shs_checker import shs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    pending,
  output int                    fail_count
);

  localparam int POS_MAX = (1 <<< (POSITION_WIDTH - 1)) - 1;
  localparam int POS_MIN = -POS_MAX - 1;

  cfg_t        cfg;
  logic        prev_a, prev_b, pend_a, pend_b;
  logic [31:0] press_a, press_b, run_t0;
  logic        homing, zero_known, jogging, jog_tared;
  logic [7:0]  stall_cnt;
  pos_t        last_pos;

  res_t        due_results[$];
  int          n_results;

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("MISMATCH %s", msg);
    fail_count++;
  endtask

  function automatic pos_t step_target(input pos_t p);
    int s;
    s = int'(p) + STEP_COUNTS;
    if (s > POS_MAX) s = POS_MAX;
    if (s < POS_MIN) s = POS_MIN;
    return pos_t'(s);
  endfunction

  // one stall evaluation: over-current or too little movement
  function automatic void count_stall(input pos_t p, input logic [11:0] cur);
    int delta;
    delta = int'(p) - int'(last_pos);
    if (delta < 0) delta = -delta;
    if (cur >= cfg.cur_limit || delta < int'(cfg.stall_eps)) begin
      if (stall_cnt != 8'hFF) stall_cnt++;
    end else begin
      stall_cnt = 8'd0;
    end
  endfunction

  function automatic res_t advance_sequencer(input item_t it);
    res_t              r;
    logic [31:0]       el;
    logic              contact;
    logic [1:0]        act;
    pos_t              tgt;
    logic signed [7:0] pwr;
    logic              tare_now;
    act      = ACT_NONE;
    tgt      = '0;
    pwr      = '0;
    tare_now = 1'b0;

    if (it.button_a && !prev_a) begin
      pend_a  = 1'b1;
      press_a = it.now_ms;
    end
    if (it.button_b && !prev_b) begin
      pend_b  = 1'b1;
      press_b = it.now_ms;
    end
    prev_a = it.button_a;
    prev_b = it.button_b;

    if (pend_a && pend_b) begin
      homing = 1'b0;
      act    = ACT_MOVE;
      tgt    = cfg.match_angle;
      pend_a = 1'b0;
      pend_b = 1'b0;
    end else if (pend_a && (it.now_ms - press_a) >= 32'(cfg.chord_window)) begin
      homing = 1'b0;
      act    = ACT_MOVE;
      tgt    = zero_known ? cfg.par_angle : step_target(it.joint_position);
      pend_a = 1'b0;
    end else if (pend_b && (it.now_ms - press_b) >= 32'(cfg.chord_window)) begin
      homing    = 1'b1;
      run_t0    = it.now_ms;
      stall_cnt = 8'd0;
      last_pos  = it.joint_position;
      pend_b    = 1'b0;
    end

    if (homing) begin
      el      = it.now_ms - run_t0;
      contact = 1'b0;
      act     = ACT_POWER;
      pwr     = PWR_HOMING;
      if (el >= 32'(cfg.grace)) begin
        count_stall(it.joint_position, it.motor_current);
        contact = (stall_cnt >= cfg.stall_limit) || (el >= 32'(cfg.timeout));
      end
      last_pos = it.joint_position;
      if (contact) begin
        act        = ACT_HOLD;
        pwr        = '0;
        tare_now   = 1'b1;
        zero_known = 1'b1;
        homing     = 1'b0;
        stall_cnt  = 8'd0;
      end
    end

    if (it.jog_up || it.jog_down) begin
      // first jog tick cancels homing and restarts the shared stall tracking
      if (!jogging) begin
        homing    = 1'b0;
        stall_cnt = 8'd0;
        jog_tared = 1'b0;
        last_pos  = it.joint_position;
        run_t0    = it.now_ms;
      end
      act     = ACT_POWER;
      tgt     = '0;
      pwr     = it.jog_up ? PWR_JOG_UP : PWR_JOG_DOWN;
      jogging = 1'b1;
      if (it.jog_down && !jog_tared) begin
        if ((it.now_ms - run_t0) >= 32'(cfg.grace)) begin
          count_stall(it.joint_position, it.motor_current);
          if (stall_cnt >= cfg.stall_limit) begin
            pwr        = '0;
            tare_now   = 1'b1;
            zero_known = 1'b1;
            jog_tared  = 1'b1;
            stall_cnt  = 8'd0;
          end
        end
        last_pos = it.joint_position;
      end
    end else if (jogging) begin
      act     = ACT_HOLD;
      tgt     = '0;
      pwr     = '0;
      jogging = 1'b0;
    end

    if (act != ACT_MOVE) tgt = '0;
    if (act != ACT_POWER) pwr = '0;
    r.action        = act;
    r.target_angle  = tgt;
    r.drive_power   = pwr;
    r.tare          = tare_now;
    r.zeroed        = zero_known;
    r.homing_active = homing;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t got, want;
    if (!rst_n) begin
      cfg.chord_window = 16'd100;
      cfg.grace        = 16'd250;
      cfg.timeout      = 16'd3000;
      cfg.cur_limit    = 12'd1200;
      cfg.stall_eps    = 16'd77;
      cfg.stall_limit  = 8'd10;
      cfg.match_angle  = pos_t'(25600);
      cfg.par_angle    = pos_t'(23040);
      {prev_a, prev_b, pend_a, pend_b} = 4'b0;
      {homing, zero_known, jogging, jog_tared} = 4'b0;
      press_a   = '0;
      press_b   = '0;
      run_t0    = '0;
      stall_cnt = '0;
      last_pos  = '0;
      due_results.delete();
      pending   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_CHORD_WINDOW: cfg.chord_window = cfg_wdata[15:0];
          REG_GRACE:        cfg.grace        = cfg_wdata[15:0];
          REG_TIMEOUT:      cfg.timeout      = cfg_wdata[15:0];
          REG_CUR_LIMIT:    cfg.cur_limit    = cfg_wdata[11:0];
          REG_STALL_EPS:    cfg.stall_eps    = cfg_wdata[15:0];
          REG_STALL_LIMIT:  cfg.stall_limit  = cfg_wdata[7:0];
          REG_MATCH_ANGLE:  cfg.match_angle  = cfg_wdata;
          REG_PAR_ANGLE:    cfg.par_angle    = cfg_wdata;
          default: ;
        endcase
      end
      // compare before queuing this edge's tick: its result cannot be out yet
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(res_t)-1:0];
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                    n_results));
        end else begin
          want = due_results.pop_front();
          if (got.action !== want.action)
            report_mismatch($sformatf("result %0d action: got %0d, want %0d",
                                      n_results, got.action, want.action));
          if (got.target_angle !== want.target_angle)
            report_mismatch($sformatf("result %0d target_angle: got %0d, want %0d",
                                      n_results, got.target_angle, want.target_angle));
          if (got.drive_power !== want.drive_power)
            report_mismatch($sformatf("result %0d drive_power: got %0d, want %0d",
                                      n_results, got.drive_power, want.drive_power));
          if (got.tare !== want.tare)
            report_mismatch($sformatf("result %0d tare: got %0d, want %0d",
                                      n_results, got.tare, want.tare));
          if (got.zeroed !== want.zeroed)
            report_mismatch($sformatf("result %0d zeroed: got %0d, want %0d",
                                      n_results, got.zeroed, want.zeroed));
          if (got.homing_active !== want.homing_active)
            report_mismatch($sformatf("result %0d homing_active: got %0d, want %0d",
                                      n_results, got.homing_active, want.homing_active));
        end
        n_results++;
      end
      if (in_tvalid && in_tready)
        due_results.push_back(advance_sequencer(in_tdata[$bits(item_t)-1:0]));
      pending = due_results.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the stall homing sequencer
// Drives control ticks in random bursts through a directed opening and six
// register settings, stalls the result side on shifting patterns, and lets
// shs_checker predict and compare every result transaction.
// ----------------------------------------------------------------------------
module tb_top import shs_pkg::*; ();

  localparam int POS_MAX = (1 <<< (POSITION_WIDTH - 1)) - 1;
  localparam int POS_MIN = -POS_MAX - 1;

  // Longest stretch without any transaction in a correct run is the receiver
  // hold-off plus a sender gap, or a register programming pass. The limit is
  // many times that.
  localparam int NO_PROGRESS_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES   = 80;
  localparam int PHASE_TICKS       = 210;

  // button masks for directed ticks: {button_a, button_b, jog_up, jog_down}
  localparam logic [3:0] BTN_NONE = 4'b0000;
  localparam logic [3:0] BTN_A    = 4'b1000;
  localparam logic [3:0] BTN_B    = 4'b0100;
  localparam logic [3:0] JOG_UP   = 4'b0010;
  localparam logic [3:0] JOG_DN   = 4'b0001;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // now_ms, button_a, button_b, jog_up, jog_down, joint_position, motor_current
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // action, target_angle, drive_power, tare, zeroed, homing_active, zero fill
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int pending;
  int fail_count;

  // tick generator state: held button levels, joint angle, wall clock
  logic [31:0] clk_ms = 32'hFFFF_FFD0;   // starts just below the wrap
  int          joint = 0;
  logic        lvl_a = 1'b0, lvl_b = 1'b0, lvl_up = 1'b0, lvl_dn = 1'b0;
  int          burst_left = 0;
  int          sent = 0;
  bit          hold_req = 1'b0;
  int          idle_cycles = 0;

  always #6 clk = ~clk;

  stall_homing_sequencer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  shs_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // Watchdog: any cycle with a transaction on either channel resets it.
  always @(posedge clk) begin
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready))) begin
      idle_cycles++;
      if (idle_cycles >= NO_PROGRESS_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // Result side: a new random ready pattern over each random span, plus one
  // long hold-off on request so the block backs up and stalls its input.
  initial begin : rx_side
    int mode, span, k;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      for (k = 0; k < span && !hold_req; k++) begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= (k % 4 == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  function automatic int clamp_pos(input int v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // tick spacing: mostly near the 20 ms control period, some long jumps,
  // a few arbitrary enough to wrap the clock
  function automatic logic [31:0] pick_dt();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 60);
    if (r < 97) return $urandom_range(61, 5000);
    return $urandom;
  endfunction

  function automatic logic [11:0] pick_cur(input int hot_pct);
    if ($urandom_range(0, 99) < hot_pct) return 12'($urandom_range(1100, 4095));
    return 12'($urandom_range(0, 1199));
  endfunction

  // Sends one tick with the held levels; opens a random gap between bursts.
  task automatic emit(input logic [31:0] dt, input logic [11:0] cur);
    item_t it;
    int    gap;
    clk_ms            = clk_ms + dt;
    it.now_ms         = clk_ms;
    it.button_a       = lvl_a;
    it.button_b       = lvl_b;
    it.jog_up         = lvl_up;
    it.jog_down       = lvl_dn;
    it.joint_position = pos_t'(joint);
    it.motor_current  = cur;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_tdata  <= it;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic dtick(input logic [3:0] btn, input int pos, input logic [11:0] cur,
                       input logic [31:0] dt);
    {lvl_a, lvl_b, lvl_up, lvl_dn} = btn;
    joint = pos;
    emit(dt, cur);
  endtask

  // Stop offering ticks until every outstanding result has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Bits above the register width carry junk that the block must drop.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val, input int w);
    logic [CFG_DATA_W-1:0] junk;
    junk      = CFG_DATA_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= (junk << w) | val;
    @(negedge clk);
  endtask

  task automatic program_cfg(input cfg_t c);
    write_reg(REG_CHORD_WINDOW, c.chord_window, 16);
    write_reg(REG_GRACE,        c.grace,        16);
    write_reg(REG_TIMEOUT,      c.timeout,      16);
    write_reg(REG_CUR_LIMIT,    c.cur_limit,    12);
    write_reg(REG_STALL_EPS,    c.stall_eps,    16);
    write_reg(REG_STALL_LIMIT,  c.stall_limit,  8);
    write_reg(REG_MATCH_ANGLE,  c.match_angle,  24);
    write_reg(REG_PAR_ANGLE,    c.par_angle,    24);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // 0: directed setup, 1: reset values, 2: all minimums, 4: all maximums,
  // others: moderate random settings
  function automatic cfg_t phase_cfg(input int ph);
    cfg_t c;
    case (ph)
      0: begin
        c.chord_window = 16'd0;     c.grace       = 16'd0;
        c.timeout      = 16'd100;   c.cur_limit   = 12'd1000;
        c.stall_eps    = 16'd77;    c.stall_limit = 8'd2;
        c.match_angle  = pos_t'(POS_MAX);
        c.par_angle    = pos_t'(POS_MIN);
      end
      1: begin
        c.chord_window = 16'd100;   c.grace       = 16'd250;
        c.timeout      = 16'd3000;  c.cur_limit   = 12'd1200;
        c.stall_eps    = 16'd77;    c.stall_limit = 8'd10;
        c.match_angle  = pos_t'(25600);
        c.par_angle    = pos_t'(23040);
      end
      2: begin
        c.chord_window = '0;        c.grace       = '0;
        c.timeout      = '0;        c.cur_limit   = '0;
        c.stall_eps    = '0;        c.stall_limit = '0;   // ends on first check
        c.match_angle  = pos_t'(POS_MIN);
        c.par_angle    = pos_t'(POS_MAX);
      end
      4: begin
        c.chord_window = '1;        c.grace       = '1;
        c.timeout      = '1;        c.cur_limit   = '1;
        c.stall_eps    = '1;        c.stall_limit = '1;
        c.match_angle  = pos_t'(POS_MAX);
        c.par_angle    = pos_t'(POS_MIN);
      end
      default: begin
        c.chord_window = 16'($urandom_range(0, 300));
        c.grace        = 16'($urandom_range(0, 500));
        c.timeout      = 16'($urandom_range(0, 2000));
        c.cur_limit    = 12'($urandom_range(0, 4095));
        c.stall_eps    = 16'($urandom_range(0, 400));
        c.stall_limit  = 8'($urandom_range(0, 20));
        c.match_angle  = pos_t'($urandom);
        c.par_angle    = pos_t'($urandom);
      end
    endcase
    return c;
  endfunction

  // One operator sequence with random content; mostly well-formed, some noise.
  task automatic run_scenario();
    int kind, n, k, sel, step;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin   // angle button alone, then wait out the chord window
        lvl_a = 1'b1;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) emit(pick_dt(), pick_cur(5));
        lvl_a = 1'b0;
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) emit(pick_dt(), pick_cur(5));
      end
      2: begin      // chord: one button, then the other close behind
        lvl_a = 1'($urandom_range(0, 1));
        lvl_b = !lvl_a;
        emit(pick_dt(), pick_cur(5));
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) emit($urandom_range(0, 40), pick_cur(5));
        lvl_a = 1'b1;
        lvl_b = 1'b1;
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) emit(pick_dt(), pick_cur(5));
        lvl_a = 1'b0;
        lvl_b = 1'b0;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) emit(pick_dt(), pick_cur(5));
      end
      3, 4: begin   // homing: press, descend, then run into the stop
        lvl_b = 1'b1;
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) emit(pick_dt(), pick_cur(5));
        lvl_b = 1'b0;
        n = $urandom_range(3, 40);
        for (k = 0; k < n; k++) begin
          joint = clamp_pos(joint - int'($urandom_range(0, 400)));
          emit(pick_dt(), pick_cur(5));
        end
        n = $urandom_range(0, 16);
        for (k = 0; k < n; k++) begin
          joint = clamp_pos(joint + int'($urandom_range(0, 20)) - 10);
          emit(pick_dt(), pick_cur(30));
        end
      end
      5, 6: begin   // manual jog up, down or both, moving then stalled
        sel    = $urandom_range(0, 2);
        lvl_up = (sel != 1);
        lvl_dn = (sel != 0);
        n      = $urandom_range(1, 30);
        step   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 300);
        for (k = 0; k < n; k++) begin
          if (k > n / 2) step = $urandom_range(0, 5);
          joint = clamp_pos(lvl_up ? joint + step : joint - step);
          emit(pick_dt(), pick_cur(20));
        end
        lvl_up = 1'b0;
        lvl_dn = 1'b0;
        emit(pick_dt(), pick_cur(0));
      end
      7: begin      // homing cut short by a jog
        lvl_b = 1'b1;
        emit(pick_dt(), pick_cur(5));
        lvl_b = 1'b0;
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) emit(pick_dt(), pick_cur(10));
        if ($urandom_range(0, 1)) lvl_up = 1'b1;
        else lvl_dn = 1'b1;
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) emit(pick_dt(), pick_cur(30));
        lvl_up = 1'b0;
        lvl_dn = 1'b0;
        emit(pick_dt(), pick_cur(0));
      end
      8: begin      // noise on every field
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          {lvl_a, lvl_b, lvl_up, lvl_dn} = 4'($urandom);
          joint = int'(pos_t'($urandom));
          emit(pick_dt(), 12'($urandom));
        end
        {lvl_a, lvl_b, lvl_up, lvl_dn} = BTN_NONE;
      end
      default: emit($urandom, 12'($urandom));   // arbitrary clock jump
    endcase
  endtask

  initial begin : stimulus
    int  ph, phase_end;
    bit  hold_done, paused;
    hold_done = 1'b0;
    paused    = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening: zero window and grace so each case shows in a tick
    // or two; stall limit 2, match at the top, parallel at the bottom.
    program_cfg(phase_cfg(0));
    dtick(BTN_NONE,        0,           12'd0,    32'd0);
    dtick(BTN_A,           POS_MAX - 100, 12'd0,  32'd20);   // step saturates
    dtick(BTN_NONE,        0,           12'hFFF,  32'd30);   // clock wraps
    dtick(BTN_A | BTN_B,   0,           12'd0,    32'd20);   // chord
    dtick(BTN_NONE,        0,           12'd0,    32'd20);
    dtick(BTN_B,           5000,        12'hFFF,  32'd20);   // homing, over-current
    dtick(BTN_B,           5000,        12'hFFF,  32'd20);   // contact, tare
    dtick(BTN_A,           0,           12'd0,    32'd20);   // zeroed: parallel
    dtick(JOG_DN,          POS_MIN,     12'd0,    32'd20);
    dtick(JOG_DN,          POS_MIN,     12'd0,    32'd20);   // jog stall tare
    dtick(JOG_DN,          POS_MIN,     12'd0,    32'd20);   // tared once only
    dtick(BTN_NONE,        POS_MIN,     12'd0,    32'd20);   // release holds
    dtick(JOG_UP | JOG_DN, 100,         12'd0,    32'd20);   // both: drive up
    dtick(JOG_UP | JOG_DN, 100,         12'd0,    32'd20);
    dtick(BTN_NONE,        100,         12'd0,    32'd20);
    dtick(BTN_B,           9000,        12'd0,    32'd20);   // no movement
    dtick(BTN_NONE,        1000,        12'd0,    32'd200);  // timeout
    dtick(BTN_B,           20000,       12'd0,    32'd20);
    dtick(BTN_B | JOG_UP,  15000,       12'd0,    32'd20);   // jog cancels run
    dtick(JOG_UP,          15000,       12'd0,    32'd20);
    dtick(BTN_NONE,        15000,       12'd0,    32'd20);
    dtick(BTN_NONE,        POS_MIN,     12'hFFF,  32'h8000_0000);

    for (ph = 1; ph <= 6; ph++) begin
      drain();
      program_cfg(phase_cfg(ph));
      phase_end = sent + PHASE_TICKS;
      while (sent < phase_end) begin
        // receiver holds off while ticks keep coming
        if (ph == 3 && !hold_done && sent > phase_end - 150) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        // sender pause mid-phase until every result is back
        if (ph == 5 && !paused && sent > phase_end - 100) begin
          drain();
          paused = 1'b1;
        end
        run_scenario();
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
